@@ sv/adm3a_pkg.sv @@
// Shared types and constants for the terminal text engine.
// No dependencies.
`default_nettype none
package adm3a_pkg;
  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [4:0] read_row;
    logic [6:0] read_column;
  } in_item_t;

  typedef struct packed {
    logic [7:0] cell_char;
    logic [4:0] cell_attribute;
    logic [4:0] cursor_row_now;
    logic [6:0] cursor_column_now;
    logic       cursor_shown;
    logic       bell_pulse;
    logic       unknown_escape;
    logic       unknown_control;
  } out_item_t;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL   = 8'h7F;
  localparam logic [7:0] CH_GRAVE = 8'h60;
  localparam logic [7:0] CH_ESC   = 8'h1B;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ETB   = 8'h17;
  localparam logic [7:0] CH_CAN   = 8'h18;
  localparam logic [7:0] CH_SUB   = 8'h1A;
  localparam logic [7:0] CH_RS    = 8'h1E;

  localparam logic [4:0] ATTR_REVERSE = 5'h01;
  localparam logic [4:0] ATTR_PIXEL   = 5'h10;

  // Datapath sweep operations
  typedef enum logic [1:0] {
    OP_FILL = 2'd0,
    OP_UP   = 2'd1,
    OP_DOWN = 2'd2
  } sweep_op_t;

  // Command from controller to datapath
  typedef struct packed {
    logic       start;
    sweep_op_t  op;
    logic [4:0] row_lo;
    logic [4:0] row_hi;
    logic [6:0] col_lo;
    logic [4:0] blank_row;
  } sweep_cmd_t;

  typedef struct packed {
    logic busy;
  } sweep_sts_t;
endpackage
`default_nettype wire

@@ sv/adm3a_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module adm3a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2000
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ sv/adm3a_dp.sv @@
// Cell store datapath: char and attribute RAMs, single-cell access and row sweeps.
// Depends on adm3a_pkg and adm3a_ram.
`default_nettype none
module adm3a_dp
  import adm3a_pkg::*;
#(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire sweep_cmd_t cmd,
  output sweep_sts_t      sts,
  input  wire logic       cell_we,
  input  wire logic [4:0] cell_row,
  input  wire logic [6:0] cell_col,
  input  wire logic [7:0] cell_ch,
  input  wire logic [4:0] cell_at,
  input  wire logic [4:0] rd_row,
  input  wire logic [6:0] rd_col,
  output logic      [7:0] rd_ch,
  output logic      [4:0] rd_at
);
  localparam int CELLS = ROWS * COLUMNS;
  localparam int AW    = $clog2(CELLS);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_WRITE} sw_state_t;
  sw_state_t  st_r;
  sweep_op_t  op_r;
  logic [4:0] row_r, row_lo_r, row_hi_r, blank_r;
  logic [6:0] col_r;

  logic [AW-1:0] waddr, raddr;
  logic          we;
  logic [7:0]    wch, rch;
  logic [4:0]    wat, rat;
  logic          is_blank;
  logic [4:0]    src_row;

  function automatic logic [AW-1:0] addr_of(input logic [4:0] r, input logic [6:0] c);
    logic [AW+7:0] a;
    a = AW'(r) * AW'(COLUMNS) + AW'(c);
    return a[AW-1:0];
  endfunction

  always_comb begin
    is_blank = (op_r == OP_FILL) || (row_r == blank_r);
    src_row  = (op_r == OP_UP) ? row_r + 5'd1 : row_r - 5'd1;
    if (st_r == S_IDLE) raddr = addr_of(rd_row, rd_col);
    else                raddr = addr_of(src_row, col_r);
    if (st_r == S_WRITE) begin
      we    = 1'b1;
      waddr = addr_of(row_r, col_r);
      wch   = is_blank ? CH_SPACE : rch;
      wat   = is_blank ? 5'd0 : rat;
    end else begin
      we    = cell_we;
      waddr = addr_of(cell_row, cell_col);
      wch   = cell_ch;
      wat   = cell_at;
    end
  end

  adm3a_ram #(.WIDTH(8), .DEPTH(CELLS)) u_chr (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wch), .raddr(raddr), .rdata(rch));
  adm3a_ram #(.WIDTH(5), .DEPTH(CELLS)) u_att (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wat), .raddr(raddr), .rdata(rat));

  assign rd_ch   = rch;
  assign rd_at   = rat;
  assign sts.busy = (st_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      // reset starts a fill of the whole store
      st_r     <= S_READ;
      op_r     <= OP_FILL;
      row_r    <= '0;
      row_lo_r <= '0;
      row_hi_r <= 5'(ROWS - 1);
      col_r    <= '0;
      blank_r  <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: begin
          if (cmd.start) begin
            op_r     <= cmd.op;
            blank_r  <= cmd.blank_row;
            col_r    <= cmd.col_lo;
            row_hi_r <= cmd.row_hi;
            row_lo_r <= cmd.row_lo;
            row_r    <= (cmd.op == OP_DOWN) ? cmd.row_hi : cmd.row_lo;
            st_r     <= S_READ;
          end
        end
        S_READ: st_r <= S_WRITE;
        S_WRITE: begin
          st_r <= S_READ;
          if (col_r == 7'(COLUMNS - 1)) begin
            col_r <= '0;
            if (op_r == OP_DOWN) begin
              if (row_r == row_lo_r) st_r <= S_IDLE;
              else row_r <= row_r - 5'd1;
            end else begin
              if (row_r == row_hi_r) st_r <= S_IDLE;
              else row_r <= row_r + 5'd1;
            end
          end else begin
            col_r <= col_r + 7'd1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/adm3a_ctl.sv @@
// Escape parser, cursor and mode state, and sweep sequencing.
// Depends on adm3a_pkg.
`default_nettype none
module adm3a_ctl
  import adm3a_pkg::*;
#(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TEXT_ROWS = 24
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_item_t   in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_item_t       out_data,
  output sweep_cmd_t      cmd,
  input  wire sweep_sts_t sts,
  output logic            cell_we,
  output logic [4:0]      cell_row,
  output logic [6:0]      cell_col,
  output logic [7:0]      cell_ch,
  output logic [4:0]      cell_at,
  output logic [4:0]      rd_row,
  output logic [6:0]      rd_col,
  input  wire logic [7:0] rd_ch,
  input  wire logic [4:0] rd_at
);
  localparam int TR = (TEXT_ROWS < ROWS) ? TEXT_ROWS : ROWS;
  localparam logic [4:0] TR_M1   = 5'(TR - 1);
  localparam logic [4:0] ROWS_M1 = 5'(ROWS - 1);
  localparam logic [6:0] COL_M1  = 7'(COLUMNS - 1);

  typedef enum logic [2:0] {C_IDLE, C_EXEC, C_RDWAIT, C_SWEEP, C_SWEEP2, C_OUT} ctl_state_t;
  typedef enum logic [1:0] {PH_IDLE, PH_LEAD, PH_ARGS} esc_phase_t;

  ctl_state_t st_r;
  in_item_t   it_r;
  logic       model_r;
  logic [4:0] crow_r, srow_r, attr_r;
  logic [6:0] ccol_r, scol_r;
  esc_phase_t phase_r;
  logic [7:0] lead_r, arg0_r, arg1_r;
  logic [2:0] need_r, taken_r;
  logic       vis_r, gmode_r, gpend_r, gbit_r, spres_r;
  logic       bell_r, uesc_r, uctl_r, rd_ok_r;
  // pending second sweep (erase-to-end clears rest of line, then rows)
  logic       sw2_r;
  sweep_cmd_t sw2_cmd_r;
  logic [7:0] och_r;
  logic [4:0] oat_r;

  logic [4:0] region_m1, top_m1;
  logic       region_full;

  always_comb begin
    region_full = model_r && !spres_r;
    region_m1   = region_full ? ROWS_M1 : TR_M1;
    top_m1      = model_r ? ROWS_M1 : TR_M1;
  end

  function automatic logic [4:0] clamp_row(input logic [7:0] v, input logic [4:0] mx);
    logic [7:0] d;
    d = v - CH_SPACE;
    if (v < CH_SPACE) return 5'd0;
    if (d > {3'b0, mx}) return mx;
    return d[4:0];
  endfunction

  function automatic logic [6:0] clamp_col(input logic [7:0] v);
    logic [7:0] d;
    d = v - CH_SPACE;
    if (v < CH_SPACE) return 7'd0;
    if (d > {1'b0, COL_M1}) return COL_M1;
    return d[6:0];
  endfunction

  assign in_ready  = (st_r == C_IDLE) && !sts.busy;
  assign out_valid = (st_r == C_OUT);
  assign rd_row    = in_data.read_row;
  assign rd_col    = in_data.read_column;

  always_comb begin
    out_data.cell_char         = och_r;
    out_data.cell_attribute    = oat_r;
    out_data.cursor_row_now    = crow_r;
    out_data.cursor_column_now = ccol_r;
    out_data.cursor_shown      = vis_r;
    out_data.bell_pulse        = bell_r;
    out_data.unknown_escape    = uesc_r;
    out_data.unknown_control   = uctl_r;
  end

  // Next-state of an executed byte
  logic       x_we, x_sw, x_sw2;
  logic [4:0] x_wrow, x_wat;
  logic [6:0] x_wcol;
  logic [7:0] x_wch;
  sweep_cmd_t x_cmd, x_cmd2;
  logic [4:0] crow_nxt, srow_nxt, attr_nxt;
  logic [6:0] ccol_nxt, scol_nxt;
  esc_phase_t phase_nxt;
  logic [7:0] lead_nxt, arg0_nxt, arg1_nxt;
  logic [2:0] need_nxt, taken_nxt;
  logic       vis_nxt, gmode_nxt, gpend_nxt, gbit_nxt, spres_nxt;
  logic       bell_nxt, uesc_nxt, uctl_nxt;

  always_comb begin
    logic [7:0] ch, low7, run_lead;
    logic       do_put, do_down, do_run, known;
    logic [7:0] pch;
    logic [4:0] pat;
    logic [2:0] nargs;
    logic [7:0] anum;
    logic [4:0] abit;
    ch = it_r.data_byte;
    low7 = {1'b0, ch[6:0]};
    x_we = 1'b0; x_sw = 1'b0; x_sw2 = 1'b0;
    x_wrow = crow_r; x_wcol = ccol_r; x_wch = ch; x_wat = attr_r;
    x_cmd = '0; x_cmd2 = '0;
    crow_nxt = crow_r; ccol_nxt = ccol_r; srow_nxt = srow_r; scol_nxt = scol_r;
    attr_nxt = attr_r;
    phase_nxt = phase_r; lead_nxt = lead_r; arg0_nxt = arg0_r; arg1_nxt = arg1_r;
    need_nxt = need_r; taken_nxt = taken_r;
    vis_nxt = vis_r; gmode_nxt = gmode_r; gpend_nxt = gpend_r; gbit_nxt = gbit_r;
    spres_nxt = spres_r;
    bell_nxt = 1'b0; uesc_nxt = 1'b0; uctl_nxt = 1'b0;
    do_put = 1'b0; do_down = 1'b0; do_run = 1'b0; run_lead = lead_r;
    pch = ch; pat = attr_r; nargs = 3'd0; known = 1'b0; anum = arg0_r; abit = 5'd0;

    if (phase_r == PH_LEAD) begin
      known = 1'b1;
      if (ch == "=") nargs = 3'd2;
      else if (!model_r) known = 1'b0;
      else if (ch == "B" || ch == "C") nargs = 3'd1;
      else if (ch == "R" || ch == "E" || ch == "A") nargs = 3'd0;
      else if (ch == "*" || ch == " ") nargs = 3'd2;
      else if (ch == "L" || ch == "D") nargs = 3'd4;
      else known = 1'b0;
      if (!known) begin
        uesc_nxt = 1'b1; phase_nxt = PH_IDLE;
      end else begin
        lead_nxt = ch; taken_nxt = 3'd0; need_nxt = nargs;
        if (nargs == 3'd0) begin
          phase_nxt = PH_IDLE; do_run = 1'b1; run_lead = ch;
        end else phase_nxt = PH_ARGS;
      end
    end else if (phase_r == PH_ARGS) begin
      if (taken_r == 3'd0) begin arg0_nxt = ch; anum = ch; end
      if (taken_r == 3'd1) arg1_nxt = ch;
      taken_nxt = taken_r + 3'd1;
      need_nxt  = need_r - 3'd1;
      if (need_nxt == 3'd0) begin phase_nxt = PH_IDLE; do_run = 1'b1; end
    end else if (ch[7]) begin
      if (!gmode_r) begin
        do_put = 1'b1;
        if (low7 >= CH_SPACE && low7 != CH_DEL) begin
          pch = low7; pat = attr_r | ATTR_REVERSE;
        end
      end else if (!gpend_r) begin
        gpend_nxt = 1'b1; gbit_nxt = ch[0];
      end else begin
        gpend_nxt = 1'b0; do_put = 1'b1;
        pat = (attr_r & ~ATTR_PIXEL) | (gbit_r ? ATTR_PIXEL : 5'd0);
      end
    end else if (ch < CH_SPACE) begin
      unique case (ch)
        CH_NUL: begin do_put = 1'b1; pch = CH_GRAVE; end
        CH_BEL: bell_nxt = 1'b1;
        CH_BS:  if (ccol_r != 7'd0) ccol_nxt = ccol_r - 7'd1;
        CH_LF:  do_down = 1'b1;
        CH_VT:  if (crow_r != 5'd0) crow_nxt = crow_r - 5'd1;
        CH_FF: begin
          if (ccol_r >= COL_M1) begin ccol_nxt = 7'd0; do_down = 1'b1; end
          else ccol_nxt = ccol_r + 7'd1;
        end
        CH_CR:  ccol_nxt = 7'd0;
        CH_ETB: begin
          if ({2'b0, crow_r} < 7'(ROWS)) begin
            x_sw = 1'b1;
            x_cmd = '{start: 1'b1, op: OP_FILL, row_lo: crow_r, row_hi: crow_r,
                      col_lo: ccol_r, blank_row: 5'd0};
            if (crow_r < region_m1) begin
              x_sw2 = 1'b1;
              x_cmd2 = '{start: 1'b1, op: OP_FILL, row_lo: crow_r + 5'd1, row_hi: region_m1,
                         col_lo: 7'd0, blank_row: 5'd0};
            end
          end
        end
        CH_CAN: begin
          if ({2'b0, crow_r} < 7'(ROWS)) begin
            x_sw = 1'b1;
            x_cmd = '{start: 1'b1, op: OP_FILL, row_lo: crow_r, row_hi: crow_r,
                      col_lo: ccol_r, blank_row: 5'd0};
          end
        end
        CH_SUB: begin
          x_sw = 1'b1;
          x_cmd = '{start: 1'b1, op: OP_FILL, row_lo: 5'd0, row_hi: region_m1,
                    col_lo: 7'd0, blank_row: 5'd0};
          crow_nxt = 5'd0; ccol_nxt = 7'd0;
        end
        CH_ESC: phase_nxt = PH_LEAD;
        CH_RS: begin crow_nxt = 5'd0; ccol_nxt = 7'd0; end
        default: uctl_nxt = 1'b1;
      endcase
    end else if (ch != CH_DEL) begin
      do_put = 1'b1;
    end

    if (do_run) begin
      if (run_lead == "=") begin
        crow_nxt = clamp_row(arg0_nxt, top_m1);
        ccol_nxt = clamp_col(arg1_nxt);
      end else if (run_lead == "B" || run_lead == "C") begin
        abit = 5'd0;
        if (anum == "0") abit = 5'h01;
        else if (anum == "1") abit = 5'h02;
        else if (anum == "2") abit = 5'h04;
        else if (anum == "3") abit = 5'h08;
        else if (anum == "4") vis_nxt = (run_lead == "B");
        else if (anum == "5") begin gmode_nxt = (run_lead == "B"); gpend_nxt = 1'b0; end
        else if (anum == "6") begin
          if (run_lead == "B") begin srow_nxt = crow_r; scol_nxt = ccol_r; end
          else begin
            crow_nxt = (srow_r > top_m1) ? top_m1 : srow_r;
            ccol_nxt = (scol_r > COL_M1) ? COL_M1 : scol_r;
          end
        end else if (anum == "7") spres_nxt = (run_lead == "B");
        else uesc_nxt = 1'b1;
        if (run_lead == "B") attr_nxt = attr_r | abit;
        else attr_nxt = attr_r & ~abit;
      end else if (run_lead == "R" || run_lead == "E") begin
        if (crow_r <= region_m1) begin
          x_sw = 1'b1;
          if (run_lead == "R")
            x_cmd = '{start: 1'b1, op: OP_UP, row_lo: crow_r, row_hi: region_m1,
                      col_lo: 7'd0, blank_row: region_m1};
          else
            x_cmd = '{start: 1'b1, op: OP_DOWN, row_lo: crow_r, row_hi: region_m1,
                      col_lo: 7'd0, blank_row: crow_r};
        end
      end
    end

    if (do_put) begin
      x_we = ({2'b0, crow_r} < 7'(ROWS)); x_wch = pch; x_wat = pat;
      if (ccol_r >= COL_M1) begin ccol_nxt = 7'd0; do_down = 1'b1; end
      else ccol_nxt = ccol_r + 7'd1;
    end

    if (do_down) begin
      if (crow_r < region_m1) crow_nxt = crow_r + 5'd1;
      else if (crow_r == region_m1) begin
        x_sw = 1'b1;
        x_cmd = '{start: 1'b1, op: OP_UP, row_lo: 5'd0, row_hi: region_m1,
                  col_lo: 7'd0, blank_row: region_m1};
      end
    end
  end

  assign cell_we  = (st_r == C_EXEC) && x_we;
  assign cell_row = x_wrow;
  assign cell_col = x_wcol;
  assign cell_ch  = x_wch;
  assign cell_at  = x_wat;

  always_comb begin
    cmd = '0;
    if (st_r == C_EXEC && x_sw) cmd = x_cmd;
    else if (st_r == C_SWEEP && !sts.busy && sw2_r) cmd = sw2_cmd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= C_IDLE; model_r <= 1'b0;
      crow_r <= '0; ccol_r <= '0; srow_r <= '0; scol_r <= '0; attr_r <= '0;
      phase_r <= PH_IDLE; lead_r <= '0; arg0_r <= '0; arg1_r <= '0;
      need_r <= '0; taken_r <= '0;
      vis_r <= 1'b1; gmode_r <= 1'b0; gpend_r <= 1'b0; gbit_r <= 1'b0; spres_r <= 1'b1;
      bell_r <= 1'b0; uesc_r <= 1'b0; uctl_r <= 1'b0; sw2_r <= 1'b0;
      och_r <= '0; oat_r <= '0; rd_ok_r <= 1'b0;
    end else begin
      if (cfg_we) model_r <= cfg_data;
      unique case (st_r)
        C_IDLE: begin
          if (in_valid && in_ready) begin
            it_r <= in_data;
            bell_r <= 1'b0; uesc_r <= 1'b0; uctl_r <= 1'b0;
            if (in_data.kind) begin
              rd_ok_r <= ({2'b0, in_data.read_row} < 7'(ROWS)) &&
                         ({1'b0, in_data.read_column} < 8'(COLUMNS));
              st_r <= C_RDWAIT;
            end else begin
              st_r <= C_EXEC;
            end
          end
        end
        C_RDWAIT: begin
          och_r <= rd_ok_r ? rd_ch : 8'd0;
          oat_r <= rd_ok_r ? rd_at : 5'd0;
          st_r  <= C_OUT;
        end
        C_EXEC: begin
          och_r <= '0; oat_r <= '0;
          crow_r <= crow_nxt; ccol_r <= ccol_nxt; srow_r <= srow_nxt; scol_r <= scol_nxt;
          attr_r <= attr_nxt; phase_r <= phase_nxt; lead_r <= lead_nxt;
          arg0_r <= arg0_nxt; arg1_r <= arg1_nxt; need_r <= need_nxt; taken_r <= taken_nxt;
          vis_r <= vis_nxt; gmode_r <= gmode_nxt; gpend_r <= gpend_nxt; gbit_r <= gbit_nxt;
          spres_r <= spres_nxt; bell_r <= bell_nxt; uesc_r <= uesc_nxt; uctl_r <= uctl_nxt;
          sw2_r <= x_sw2; sw2_cmd_r <= x_cmd2;
          st_r <= x_sw ? C_SWEEP : C_OUT;
        end
        C_SWEEP: begin
          if (!sts.busy) begin
            if (sw2_r) begin sw2_r <= 1'b0; st_r <= C_SWEEP2; end
            else st_r <= C_OUT;
          end
        end
        C_SWEEP2: if (!sts.busy) st_r <= C_OUT;
        C_OUT: if (out_ready) st_r <= C_IDLE;
        default: st_r <= C_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ sv/adm3a_terminal_text_engine.sv @@
// Top level of the terminal text engine: controller plus cell-store datapath.
// Depends on adm3a_pkg, adm3a_ctl, adm3a_dp.
// A read item passes through a read-wait state and a plain byte through an execute state
// before its result is offered, and the next input is taken at the earliest in the cycle
// after the result transfer. Scroll, insert or delete line and clears sweep the affected
// rows cell by cell (read then write on the single write port). After reset the store is
// filled with spaces and attribute 0, which holds in_ready low until the fill is done; the
// user must offer configuration only while the block is idle; the block does not enforce it.
`default_nettype none
module adm3a_terminal_text_engine
  import adm3a_pkg::*;
#(
  parameter int COLUMNS   = 80,
  parameter int ROWS      = 25,
  parameter int TEXT_ROWS = 24
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_we,
  input  wire logic     cfg_data,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);
  sweep_cmd_t cmd;
  sweep_sts_t sts;
  logic       cell_we;
  logic [4:0] cell_row, cell_at, rd_row, rd_at;
  logic [6:0] cell_col, rd_col;
  logic [7:0] cell_ch, rd_ch;

  adm3a_ctl #(.COLUMNS(COLUMNS), .ROWS(ROWS), .TEXT_ROWS(TEXT_ROWS)) u_ctl (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cmd(cmd), .sts(sts), .cell_we(cell_we), .cell_row(cell_row), .cell_col(cell_col),
    .cell_ch(cell_ch), .cell_at(cell_at), .rd_row(rd_row), .rd_col(rd_col),
    .rd_ch(rd_ch), .rd_at(rd_at));

  adm3a_dp #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .cell_we(cell_we),
    .cell_row(cell_row), .cell_col(cell_col), .cell_ch(cell_ch), .cell_at(cell_at),
    .rd_row(rd_row), .rd_col(rd_col), .rd_ch(rd_ch), .rd_at(rd_at));
endmodule
`default_nettype wire
